FILE: rtl/b64enc_pkg.sv
// Shared types, constants and the character table for the base64 encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

	localparam int unsigned FIFO_DEPTH = 2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Number of '=' characters that close a group.
	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_ONE,
		PAD_TWO
	} pad_t;

	typedef struct packed {
		logic [23:0] bits;
		pad_t        pad;
		logic        last;
	} group_t;

	// Maps a 6-bit field to its character of the standard alphabet.
	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		logic [7:0] c;
		begin
			if (s < 6'd26) begin
				c = 8'h41 + {2'b00, s};
			end else if (s < 6'd52) begin
				c = 8'h61 + {2'b00, s} - 8'd26;
			end else if (s < 6'd62) begin
				c = 8'h30 + {2'b00, s} - 8'd52;
			end else if (s == 6'd62) begin
				c = 8'h2B;
			end else begin
				c = 8'h2F;
			end
			return c;
		end
	endfunction

endpackage

FILE: rtl/b64enc_front.sv
// Front end: gathers input bytes into 24-bit groups and hands finished groups on.
`timescale 1ns / 1ps

module b64enc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  grp_full,
	output logic                  grp_wr,
	output b64enc_pkg::group_t    grp_data
);

	logic [15:0] pending_q;
	logic [1:0]  count_q;
	logic        accept;
	logic        closes;

	assign accept = push && !grp_full;
	assign closes = (count_q == 2'd2) || last_byte;
	assign grp_wr = accept && closes;

	always_comb begin
		grp_data.last = last_byte;
		unique case (count_q)
			2'd1: begin
				grp_data.bits = {pending_q[15:8], data_byte, 8'h00};
				grp_data.pad  = b64enc_pkg::PAD_ONE;
			end
			2'd2: begin
				grp_data.bits = {pending_q, data_byte};
				grp_data.pad  = b64enc_pkg::PAD_NONE;
			end
			default: begin
				grp_data.bits = {data_byte, 16'h0000};
				grp_data.pad  = b64enc_pkg::PAD_TWO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			count_q   <= '0;
		end else if (accept) begin
			if (closes) begin
				pending_q <= '0;
				count_q   <= '0;
			end else if (count_q == 2'd1) begin
				pending_q[7:0] <= data_byte;
				count_q        <= 2'd2;
			end else begin
				pending_q <= {data_byte, 8'h00};
				count_q   <= 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("front holds more than two pending bytes");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		grp_wr |=> count_q == 2'd0)
		else $error("pending count not cleared after a group was closed");
`endif

endmodule

FILE: rtl/b64enc_fifo.sv
// Short queue of gathered byte groups between the front and back ends.
`timescale 1ns / 1ps

module b64enc_fifo #(
	parameter int unsigned Depth = b64enc_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  b64enc_pkg::group_t    wr_data,
	output logic                  full,
	input  logic                  rd_en,
	output b64enc_pkg::group_t    rd_data,
	output logic                  head_valid
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	b64enc_pkg::group_t mem_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	assign full       = (count_q == DepthCnt);
	assign head_valid = (count_q != '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en)
		else $error("group written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> head_valid)
		else $error("group read from an empty queue");
`endif

endmodule

FILE: rtl/b64enc_back.sv
// Back end: turns each queued group into four characters, one per cycle while pop takes them.
`timescale 1ns / 1ps

module b64enc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64enc_pkg::group_t    head,
	input  logic                  head_valid,
	output logic                  head_pop,
	output logic [7:0]            out_char,
	output logic                  out_last,
	output logic                  empty,
	input  logic                  pop
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic [5:0] sextet;
	logic       is_pad;

	assign load     = head_valid && (!valid_q || pop);
	assign head_pop = load && (idx_q == 2'd3);

	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = head.bits[23:18];
			2'd1:    sextet = head.bits[17:12];
			2'd2:    sextet = head.bits[11:6];
			default: sextet = head.bits[5:0];
		endcase
	end

	// The trailing characters of a short group are padding.
	assign is_pad = ((idx_q == 2'd3) && (head.pad != b64enc_pkg::PAD_NONE)) ||
	                ((idx_q == 2'd2) && (head.pad == b64enc_pkg::PAD_TWO));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
		end else if (load) begin
			idx_q   <= idx_q + 1'b1;
			valid_q <= 1'b1;
			char_q  <= is_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::sextet_char(sextet);
			last_q  <= (idx_q == 2'd3) && head.last;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	assign out_char = char_q;
	assign out_last = last_q;
	assign empty    = !valid_q;

`ifndef NO_ASSERTIONS
	a_last_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> idx_q == 2'd0)
		else $error("final character shown before its group ended");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !pop |=> valid_q && $stable(char_q) && $stable(idx_q))
		else $error("waiting character changed without a transfer");
`endif

endmodule

FILE: rtl/base64_encoder.sv
// Top level of the streaming base64 encoder.
`timescale 1ns / 1ps

// Streaming base64 encoder with the standard alphabet and '=' padding. Bytes
// enter one per transfer on push/full; each third byte, or a byte marked with
// last_byte, closes a group that a short queue of FifoDepth groups carries to
// the character stage. That stage shows one character per cycle on the
// empty/pop side while pop is high and a group is queued, four for every
// group, and out_last marks the fourth character of a group closed by
// last_byte. Any byte is taken in the cycle it is offered while the queue has
// room; full is high, and holds every byte back, while the queue holds
// FifoDepth groups. Over a long message the single-character output port sets
// the rate. A closed group is written into the queue, and its first character
// is registered in the character stage once the group heads the queue.
module base64_encoder #(
	parameter int unsigned FifoDepth = b64enc_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       out_last
);

	b64enc_pkg::group_t wr_grp;
	b64enc_pkg::group_t head_grp;
	logic               grp_wr;
	logic               grp_full;
	logic               head_valid;
	logic               head_pop;

	assign full = grp_full;

	b64enc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.grp_full  (grp_full),
		.grp_wr    (grp_wr),
		.grp_data  (wr_grp)
	);

	b64enc_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (grp_wr),
		.wr_data    (wr_grp),
		.full       (grp_full),
		.rd_en      (head_pop),
		.rd_data    (head_grp),
		.head_valid (head_valid)
	);

	b64enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_grp),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.out_char   (out_char),
		.out_last   (out_last),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

FILE: bench/base64_encoder_test.sv
// Self-checking bench for the streaming base64 encoder: directed groups, then random messages.
`timescale 1ns / 1ps
module base64_encoder_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 426;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;
	localparam int DIRECTED_ROWS = 24;
	localparam logic [31:0] NO_TYPED = 32'h0;
	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] typed;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_char;
	logic       out_last;

	// Characters still owed by the block, oldest first.
	char_t      awaited_chars[$];
	char_t      want;
	logic [15:0] held_bytes;
	logic [1:0]  held_count;
	logic [7:0]  group_chars [0:3];

	int errors = 0;
	int cycles = 0;
	int bytes_in = 0;
	int chars_out = 0;
	int messages = 0;
	int pop_hold = 0;
	bit no_idle = 1'b0;

	// Rows with a typed group are checked against it; the others use the predictor.
	row_t directed_rows [0:DIRECTED_ROWS-1] = '{
		'{8'h00, 1'b1, "AA=="},
		'{8'hFF, 1'b1, "/w=="},
		'{8'h00, 1'b0, NO_TYPED},
		'{8'h00, 1'b0, NO_TYPED},
		'{8'h00, 1'b0, "AAAA"},
		'{8'hFF, 1'b0, NO_TYPED},
		'{8'hFF, 1'b0, NO_TYPED},
		'{8'hFF, 1'b1, "////"},
		'{8'hFF, 1'b0, NO_TYPED},
		'{8'hFF, 1'b1, "//8="},
		'{8'h00, 1'b0, NO_TYPED},
		'{8'h00, 1'b1, "AAA="},
		'{8'h4D, 1'b0, NO_TYPED},
		'{8'h61, 1'b0, NO_TYPED},
		'{8'h6E, 1'b0, "TWFu"},
		'{8'h4D, 1'b0, NO_TYPED},
		'{8'h61, 1'b1, "TWE="},
		'{8'h4D, 1'b1, "TQ=="},
		'{8'hFB, 1'b0, NO_TYPED},
		'{8'hFF, 1'b0, NO_TYPED},
		'{8'hBF, 1'b0, "+/+/"},
		'{8'h80, 1'b0, NO_TYPED},
		'{8'h01, 1'b0, NO_TYPED},
		'{8'h7F, 1'b1, NO_TYPED}
	};

	base64_encoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.empty     (empty),
		.pop       (pop),
		.out_char  (out_char),
		.out_last  (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d characters still owed", cycles,
				awaited_chars.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic logic [7:0] sextet_of(input logic [23:0] grp, input int shift);
		logic [5:0] s;
		s = grp[shift +: 6];
		return ALPHABET[8 * (63 - int'(s)) +: 8];
	endfunction

	// Updates the held bytes and returns how many characters the byte releases.
	function automatic int encode_byte(input logic [7:0] b, input logic l);
		logic [1:0]  cnt;
		logic [23:0] grp;
		cnt = (held_count == 2'd3) ? 2'd0 : held_count;
		if (cnt < 2'd2 && !l) begin
			if (cnt == 2'd0) held_bytes = {b, 8'h00};
			else held_bytes = {held_bytes[15:8], b};
			held_count = cnt + 2'd1;
			return 0;
		end
		case (cnt)
			2'd0: grp = {b, 16'h0000};
			2'd1: grp = {held_bytes[15:8], b, 8'h00};
			default: grp = {held_bytes, b};
		endcase
		group_chars[0] = sextet_of(grp, 18);
		group_chars[1] = sextet_of(grp, 12);
		group_chars[2] = (cnt == 2'd0) ? b64enc_pkg::PAD_CHAR : sextet_of(grp, 6);
		group_chars[3] = (cnt == 2'd2) ? sextet_of(grp, 0) : b64enc_pkg::PAD_CHAR;
		held_bytes = 16'h0000;
		held_count = 2'd0;
		return 4;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input logic [31:0] typed);
		int gap;
		int n;
		int k;
		char_t c;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (full) @(posedge clk);
		n = encode_byte(b, l);
		for (k = 0; k < n; k++) begin
			c.ch = (typed != NO_TYPED) ? typed[8 * (3 - k) +: 8] : group_chars[k];
			c.last = (k == 3) && l;
			awaited_chars.push_back(c);
		end
		bytes_in++;
		if (l) messages++;
	endtask

	// Holds the input side until every owed character has been transferred.
	task automatic drain();
		push <= 1'b0;
		while (awaited_chars.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			chars_out++;
			if (awaited_chars.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("Unexpected character %h (last %b) at cycle %0d", out_char,
						out_last, cycles);
			end else begin
				want = awaited_chars.pop_front();
				if (out_char !== want.ch || out_last !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("Mismatch at cycle %0d: char %h last %b, wanted %h last %b",
							cycles, out_char, out_last, want.ch, want.last);
				end
			end
			pop_hold = no_idle ? 0 : pick_gap();
		end
		if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		int len;
		int r;
		int i;
		int burst;
		logic [7:0] b;
		held_bytes = 16'h0000;
		held_count = 2'd0;
		burst = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed);
		drain();

		// Random messages, mostly short, with occasional stretches of no idling.
		while (bytes_in < DIRECTED_ROWS + RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 70) len = $urandom_range(6, 1);
			else if (r < 95) len = $urandom_range(16, 7);
			else len = $urandom_range(40, 17);
			no_idle = ($urandom_range(7) == 0);
			for (i = 0; i < len; i++) begin
				r = $urandom_range(9);
				if (r == 0) b = 8'h00;
				else if (r == 1) b = 8'hFF;
				else b = 8'($urandom_range(255));
				send_byte(b, i == len - 1, NO_TYPED);
			end
			burst++;
			if (burst % 25 == 0) drain();
		end
		no_idle = 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_chars.size() != 0) begin
			errors++;
			$display("%0d characters never arrived", awaited_chars.size());
		end
		$display("Encoded %0d messages from %0d bytes; %0d characters checked.", messages,
			bytes_in, chars_out);
		$display("Stalls on both sides, full-group, one-pad and two-pad endings were exercised.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("Total mismatches: %0d", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
